>>> sv/snsw_pkg.sv
`default_nettype none

package snsw_pkg;

  // fixed field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned ACC_W    = 24;
  localparam int unsigned NUM_DIMS = 4;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_INDEX  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_SEQUENCE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_kind_e;

  typedef enum logic [2:0] {
    REG_INDEX_DIMS  = 3'd0,
    REG_DIM_SIZE_0  = 3'd1,
    REG_DIM_SIZE_1  = 3'd2,
    REG_DIM_SIZE_2  = 3'd3,
    REG_DIM_SIZE_3  = 3'd4,
    REG_SLICE_LEN   = 3'd5,
    REG_TOTAL_WORDS = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    FS_IDLE  = 2'd0,
    FS_MAC   = 2'd1,
    FS_BASE  = 2'd2,
    FS_CHECK = 2'd3
  } front_state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  index_value;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              out_valid;
    status_e           status;
  } result_t;

  typedef struct packed {
    logic [2:0]                      index_dims;
    logic [NUM_DIMS-1:0][DIM_W-1:0]  dim_size;
    logic [DIM_W-1:0]                slice_len;
    logic [DIM_W-1:0]                total_words;
  } cfg_t;

  // one store operation with the status of the request that caused it
  typedef struct packed {
    op_kind_e          kind;
    logic [WORD_W-1:0] word;
    status_e           status;
  } op_t;

endpackage

`default_nettype wire

>>> sv/snsw_fifo.sv
`default_nettype none

module snsw_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [W-1:0]                 data_i,
  output logic                              full_o,
  input  wire logic                         pop_i,
  output logic [W-1:0]                      data_o,
  output logic                              empty_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  localparam int unsigned PTRW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH+1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PTRW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTRW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTRW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTRW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/snsw_front.sv
`default_nettype none

module snsw_front #(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned MAX_DIMS    = 4,
  parameter int unsigned AW          = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire snsw_pkg::cfg_t   cfg_i,
  input  wire snsw_pkg::item_t  item_i,
  input  wire logic             in_valid_i,
  output logic                  ready_o,
  input  wire logic             op_full_i,
  output logic                  op_push_o,
  output snsw_pkg::op_t         op_o,
  output logic [AW-1:0]         op_addr_o
);

  import snsw_pkg::*;

  localparam int unsigned PW   = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;
  localparam int unsigned CW   = (MAX_DIMS > 2) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned MACW = ACC_W + DIM_W + 1;
  localparam int unsigned PRW  = ACC_W + DIM_W;

  front_state_e state_q, state_d;

  logic [PW-1:0]    load_ptr_q, load_ptr_d;
  logic [PW-1:0]    read_ptr_q, read_ptr_d;
  logic [ACC_W-1:0] accum_q, accum_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [PW-1:0]    base_q, base_d;
  logic [DIM_W-1:0] offset_q, offset_d;
  logic             active_q, active_d;
  status_e          terr_q, terr_d;
  logic [MACW-1:0]  mac_q, mac_d;
  logic [PRW-1:0]   prod_q, prod_d;
  status_e          st_q, st_d;

  logic             in_fire;
  logic [PW-1:0]    limit;
  logic [3:0]       k;
  logic [3:0]       cnt_eff;
  logic [3:0]       cnt_p1;
  logic             cnt_last;
  logic [DIM_W-1:0] dim_sel;
  logic             comp_bad;
  logic [ACC_W-1:0] acc_in;
  logic [PRW-1:0]   mac_prod;
  logic             load_ok, read_ok;
  logic [PW:0]      upd_addr;
  logic             upd_ok;
  logic [DIM_W:0]   offset_p1;
  logic             ovf;

  assign ready_o = (state_q == FS_IDLE) && !op_full_i;
  assign in_fire = in_valid_i && ready_o;

  // usable store size and clamped tuple length
  always_comb begin
    if (PW'(cfg_i.total_words) < PW'(STORE_DEPTH)) begin
      limit = PW'(cfg_i.total_words);
    end else begin
      limit = PW'(STORE_DEPTH);
    end
    if (cfg_i.index_dims == 3'd0) begin
      k = 4'd1;
    end else if (4'(cfg_i.index_dims) > 4'(MAX_DIMS)) begin
      k = 4'(MAX_DIMS);
    end else begin
      k = 4'(cfg_i.index_dims);
    end
  end

  // component position and dimension lookup
  always_comb begin
    cnt_eff = (4'(cnt_q) >= k) ? 4'd0 : 4'(cnt_q);
    dim_sel = '0;
    for (int j = 0; j < NUM_DIMS; j++) begin
      if (cnt_eff == 4'(j)) begin
        dim_sel = cfg_i.dim_size[j];
      end
    end
  end

  assign cnt_p1    = 4'(cnt_q) + 4'd1;
  assign cnt_last  = (cnt_p1 >= k);
  assign comp_bad  = ({1'b0, item_i.index_value} >= dim_sel);
  assign acc_in    = (cnt_eff == 4'd0) ? '0 : accum_q;
  assign mac_prod  = acc_in * dim_sel;
  assign load_ok   = (load_ptr_q < limit);
  assign read_ok   = (read_ptr_q < limit);
  assign upd_addr  = (PW+1)'(base_q) + (PW+1)'(offset_q);
  assign upd_ok    = (upd_addr < (PW+1)'(STORE_DEPTH));
  assign offset_p1 = (DIM_W+1)'(offset_q) + 1'b1;
  assign ovf       = (terr_q == ST_OK) &&
                     ((MACW'(prod_q) + MACW'(cfg_i.slice_len)) > MACW'(limit));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: begin
        if (in_fire && item_i.cmd == CMD_INDEX && !active_q) begin
          state_d = FS_MAC;
        end
      end
      FS_MAC: begin
        state_d = cnt_last ? FS_BASE : FS_IDLE;
      end
      FS_BASE: begin
        state_d = FS_CHECK;
      end
      FS_CHECK: begin
        state_d = FS_IDLE;
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  // pointer, accumulator and slice tracking
  always_comb begin
    load_ptr_d = load_ptr_q;
    read_ptr_d = read_ptr_q;
    accum_d    = accum_q;
    cnt_d      = cnt_q;
    base_d     = base_q;
    offset_d   = offset_q;
    active_d   = active_q;
    terr_d     = terr_q;
    mac_d      = mac_q;
    prod_d     = prod_q;
    st_d       = st_q;
    case (state_q)
      FS_IDLE: begin
        if (in_fire) begin
          case (item_i.cmd)
            CMD_LOAD: begin
              if (load_ok) begin
                load_ptr_d = load_ptr_q + 1'b1;
              end
            end
            CMD_INDEX: begin
              if (!active_q) begin
                cnt_d = cnt_eff[CW-1:0];
                mac_d = {1'b0, mac_prod} + MACW'(item_i.index_value);
                st_d  = comp_bad ? ST_RANGE : ST_OK;
                if (comp_bad) begin
                  terr_d = ST_RANGE;
                end else if (cnt_eff == 4'd0) begin
                  terr_d = ST_OK;
                end
              end
            end
            CMD_UPDATE: begin
              if (active_q) begin
                if (offset_p1 >= (DIM_W+1)'(cfg_i.slice_len)) begin
                  active_d = 1'b0;
                  offset_d = '0;
                end else begin
                  offset_d = offset_p1[DIM_W-1:0];
                end
              end
            end
            CMD_READ: begin
              if (read_ok) begin
                read_ptr_d = read_ptr_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FS_MAC: begin
        accum_d = (mac_q > MACW'(ACC_MAX)) ? ACC_MAX : mac_q[ACC_W-1:0];
        cnt_d   = cnt_last ? '0 : cnt_p1[CW-1:0];
      end
      FS_BASE: begin
        prod_d = accum_q * cfg_i.slice_len;
      end
      FS_CHECK: begin
        if (ovf) begin
          terr_d = ST_OVERFLOW;
        end
        base_d   = (terr_q == ST_OK && !ovf) ? prod_q[PW-1:0] : '0;
        offset_d = '0;
        active_d = (cfg_i.slice_len != '0);
      end
      default: begin
      end
    endcase
  end

  // store operation handed to the back end
  always_comb begin
    op_push_o   = 1'b0;
    op_o.kind   = OP_NONE;
    op_o.word   = item_i.word;
    op_o.status = ST_OK;
    op_addr_o   = '0;
    case (state_q)
      FS_IDLE: begin
        if (in_fire) begin
          case (item_i.cmd)
            CMD_LOAD: begin
              op_push_o = 1'b1;
              if (load_ok) begin
                op_o.kind = OP_WRITE;
                op_addr_o = load_ptr_q[AW-1:0];
              end else begin
                op_o.status = ST_OVERFLOW;
              end
            end
            CMD_INDEX: begin
              if (active_q) begin
                op_push_o   = 1'b1;
                op_o.status = ST_SEQUENCE;
              end
            end
            CMD_UPDATE: begin
              op_push_o = 1'b1;
              if (!active_q) begin
                op_o.status = ST_SEQUENCE;
              end else if (terr_q != ST_OK) begin
                op_o.status = terr_q;
              end else if (upd_ok) begin
                op_o.kind = OP_WRITE;
                op_addr_o = upd_addr[AW-1:0];
              end
            end
            CMD_READ: begin
              op_push_o = 1'b1;
              if (read_ok) begin
                op_o.kind = OP_READ;
                op_addr_o = read_ptr_q[AW-1:0];
              end else begin
                op_o.status = ST_SEQUENCE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      FS_MAC: begin
        if (!cnt_last) begin
          op_push_o   = 1'b1;
          op_o.status = st_q;
        end
      end
      FS_CHECK: begin
        op_push_o   = 1'b1;
        op_o.status = ovf ? ST_OVERFLOW : st_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_IDLE;
      load_ptr_q <= '0;
      read_ptr_q <= '0;
      accum_q    <= '0;
      cnt_q      <= '0;
      base_q     <= '0;
      offset_q   <= '0;
      active_q   <= 1'b0;
      terr_q     <= ST_OK;
    end else begin
      state_q    <= state_d;
      load_ptr_q <= load_ptr_d;
      read_ptr_q <= read_ptr_d;
      accum_q    <= accum_d;
      cnt_q      <= cnt_d;
      base_q     <= base_d;
      offset_q   <= offset_d;
      active_q   <= active_d;
      terr_q     <= terr_d;
    end
  end

  // multiply results and per-component status
  always_ff @(posedge clk_i) begin
    mac_q  <= mac_d;
    prod_q <= prod_d;
    st_q   <= st_d;
  end

endmodule

`default_nettype wire

>>> sv/snsw_back.sv
`default_nettype none

module snsw_back #(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned AW          = 12,
  parameter int unsigned OUT_DEPTH   = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire snsw_pkg::op_t     op_i,
  input  wire logic [AW-1:0]     op_addr_i,
  input  wire logic              op_empty_i,
  output logic                   op_pop_o,
  output snsw_pkg::result_t      result_o,
  output logic                   empty_o,
  input  wire logic              pop_i
);

  import snsw_pkg::*;

  localparam int unsigned CNTW = $clog2(OUT_DEPTH+1);

  logic [WORD_W-1:0] store_q [STORE_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              pend_q;
  op_kind_e          kind_q;
  status_e           status_q;
  logic [CNTW-1:0]   out_count;
  logic              out_full;
  result_t           res;

  // take an operation only when its result is sure to find room
  assign op_pop_o = !op_empty_i && !out_full &&
                    ((CNTW+1)'(out_count) + (CNTW+1)'(pend_q) < (CNTW+1)'(OUT_DEPTH));

  // data store, one access per cycle while operations are popped
  always_ff @(posedge clk_i) begin
    if (op_pop_o && op_i.kind == OP_WRITE) begin
      store_q[op_addr_i] <= op_i.word;
    end
    if (op_pop_o && op_i.kind == OP_READ) begin
      rdata_q <= store_q[op_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= op_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      kind_q   <= op_i.kind;
      status_q <= op_i.status;
    end
  end

  // build the result once the read data is back
  always_comb begin
    res.out_valid = (kind_q == OP_READ);
    res.out_word  = (kind_q == OP_READ) ? rdata_q : '0;
    res.status    = status_q;
  end

  snsw_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pend_q),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (result_o),
    .empty_o (empty_o),
    .count_o (out_count)
  );

endmodule

`default_nettype wire

>>> sv/scatter_nd_slice_writer_unit.sv
// channel   | direction | handshake                        | payload
// ----------+-----------+----------------------------------+----------------------
// request   | in        | push / full                      | item_i (cmd, word, index)
// result    | out       | empty / pop                      | result_o (word, valid, status)
// config    | in        | psel, penable, pwrite, pready    | paddr, pwdata / prdata
//
// load, update and read requests are taken every cycle while the front end is idle and the
// operation queue has room, since the back end does one store access a cycle while its result
// queue has room. An index component passes the MAC state, the last one of a tuple also
// BASE and CHECK (two registered multiplies, then the address range check). A result goes
// via the pending register into the result queue. Reset clears pointers and queues, not the
// store. While pop is low, up to six requests are taken before full rises.
`default_nettype none

module scatter_nd_slice_writer_unit #(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned MAX_DIMS    = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire snsw_pkg::item_t                   item_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output snsw_pkg::result_t                      result_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [snsw_pkg::APB_AW-1:0]       paddr,
  input  wire logic [snsw_pkg::APB_DW-1:0]       pwdata,
  output logic [snsw_pkg::APB_DW-1:0]            prdata,
  output logic                                   pready
);

  import snsw_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned QW = $bits(op_t) + AW;

  cfg_t             cfg_q, cfg_d;
  logic             cfg_wr;
  reg_idx_e         reg_idx;
  logic             front_ready;
  logic             op_push, op_full, op_empty, op_pop;
  op_t              op_in, op_out;
  logic [AW-1:0]    op_addr_in, op_addr_out;
  logic [QW-1:0]    q_out;
  logic [1:0]       op_count;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign full    = !front_ready;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_INDEX_DIMS:  cfg_d.index_dims  = pwdata[2:0];
        REG_DIM_SIZE_0:  cfg_d.dim_size[0] = pwdata[DIM_W-1:0];
        REG_DIM_SIZE_1:  cfg_d.dim_size[1] = pwdata[DIM_W-1:0];
        REG_DIM_SIZE_2:  cfg_d.dim_size[2] = pwdata[DIM_W-1:0];
        REG_DIM_SIZE_3:  cfg_d.dim_size[3] = pwdata[DIM_W-1:0];
        REG_SLICE_LEN:   cfg_d.slice_len   = pwdata[DIM_W-1:0];
        REG_TOTAL_WORDS: cfg_d.total_words = pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_INDEX_DIMS:  prdata = APB_DW'(cfg_q.index_dims);
      REG_DIM_SIZE_0:  prdata = APB_DW'(cfg_q.dim_size[0]);
      REG_DIM_SIZE_1:  prdata = APB_DW'(cfg_q.dim_size[1]);
      REG_DIM_SIZE_2:  prdata = APB_DW'(cfg_q.dim_size[2]);
      REG_DIM_SIZE_3:  prdata = APB_DW'(cfg_q.dim_size[3]);
      REG_SLICE_LEN:   prdata = APB_DW'(cfg_q.slice_len);
      REG_TOTAL_WORDS: prdata = APB_DW'(cfg_q.total_words);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.index_dims  <= 3'd1;
      cfg_q.dim_size    <= {NUM_DIMS{DIM_W'(1)}};
      cfg_q.slice_len   <= DIM_W'(1);
      cfg_q.total_words <= DIM_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // request classification and bookkeeping
  snsw_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_DIMS    (MAX_DIMS),
    .AW          (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (item_i),
    .in_valid_i (push),
    .ready_o    (front_ready),
    .op_full_i  (op_full),
    .op_push_o  (op_push),
    .op_o       (op_in),
    .op_addr_o  (op_addr_in)
  );

  // operation queue between front and back
  snsw_fifo #(
    .W     (QW),
    .DEPTH (2)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  ({op_addr_in, op_in}),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .data_o  (q_out),
    .empty_o (op_empty),
    .count_o (op_count)
  );

  assign op_out      = q_out[$bits(op_t)-1:0];
  assign op_addr_out = q_out[QW-1:$bits(op_t)];

  // store access and result queue
  snsw_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW),
    .OUT_DEPTH   (4)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_out),
    .op_addr_i  (op_addr_out),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .result_o   (result_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

  // read data only ever comes with an ok status
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.out_valid) |-> (result_o.status == ST_OK))
    else $error("read data with error status");

  // front end never pushes into a full operation queue
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_push |-> !op_full)
    else $error("operation queue overrun");

  // a non-index request is queued in the cycle it is taken
  a_simple_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && item_i.cmd != CMD_INDEX) |=> !op_empty)
    else $error("request not queued");

  // queue fill never exceeds its depth
  a_op_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_count <= 2'd2)
    else $error("operation queue count out of range");

endmodule

`default_nettype wire
